[rtl/adc_block_average_to_ascii_assert.svh]
// Assertion helpers shared by the block's modules.
// Each macro expects clk and arst_n in scope.
`ifndef ADC_BLOCK_AVERAGE_TO_ASCII_ASSERT_SVH
`define ADC_BLOCK_AVERAGE_TO_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ADCBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ADCBA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/adcba_pkg.sv]
`timescale 1ns / 1ps

package adcba_pkg;

	// Samples per averaged block.
	localparam int unsigned BLOCK_LEN = 10;
	localparam logic [3:0] LAST_COUNT = 4'(BLOCK_LEN - 1);

	// ASCII characters, cut to the 6-bit result fields.
	localparam logic [5:0] ASCII_ZERO  = 6'h30;
	localparam logic [5:0] ASCII_PLUS  = 6'd43;
	localparam logic [5:0] ASCII_MINUS = 6'd45;

	// floor(4*a/91) == (a * SCALE_MUL) >> SCALE_SHIFT for a <= 20480.
	localparam logic [31:0] SCALE_MUL   = 32'd184366;
	localparam int unsigned SCALE_SHIFT = 22;

	// floor(r/100) == (r * HUN_MUL) >> HUN_SHIFT for r <= 1023.
	localparam logic [15:0] HUN_MUL   = 16'd41;
	localparam int unsigned HUN_SHIFT = 12;

	// floor(r/10) == (r * TEN_MUL) >> TEN_SHIFT for r <= 99.
	localparam logic [14:0] TEN_MUL   = 15'd205;
	localparam int unsigned TEN_SHIFT = 11;

	localparam logic [9:0] THOUSAND = 10'd1000;

	// Finished block sum on its way to scaling.
	typedef struct packed {
		logic              valid;
		logic signed [15:0] sum;
	} sum_stage_t;

	// Scaled magnitude and sign on their way to digit split.
	typedef struct packed {
		logic       valid;
		logic       neg;
		logic [9:0] mag;
	} mag_stage_t;

endpackage

[rtl/adcba_in_if.sv]
`timescale 1ns / 1ps

interface adcba_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink (input valid, input adc_code, output ready);
endinterface

[rtl/adcba_out_if.sv]
`timescale 1ns / 1ps

interface adcba_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] sign_char;
	logic [5:0] digit_thousands;
	logic [5:0] digit_hundreds;
	logic [5:0] digit_tens;
	logic [5:0] digit_ones;

	modport source (
		output valid, output sign_char, output digit_thousands,
		output digit_hundreds, output digit_tens, output digit_ones,
		input ready
	);
	modport sink (
		input valid, input sign_char, input digit_thousands,
		input digit_hundreds, input digit_tens, input digit_ones,
		output ready
	);
endinterface

[rtl/adcba_accum.sv]
`timescale 1ns / 1ps
`include "adc_block_average_to_ascii_assert.svh"

module adcba_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	adcba_in_if.sink              samples,
	output adcba_pkg::sum_stage_t sum_stage,
	input  logic                  sum_taken
);
	import adcba_pkg::*;

	logic signed [15:0] sum_q;
	logic [3:0]         count_q;
	logic signed [15:0] sum_next;
	logic               accept;
	logic               last;
	logic               valid_s1;
	logic signed [15:0] sum_s1;

	// Stall only while a finished sum is still parked in the stage register
	assign samples.ready = !valid_s1 || sum_taken;
	assign accept        = samples.valid && samples.ready;
	assign last          = (count_q == LAST_COUNT);

	// Sign-extend the code and add it in
	assign sum_next = sum_q + {{4{samples.adc_code[11]}}, samples.adc_code};

	// Advance the running sum and count; clear both at the end of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 4'd1;
			end
		end
	end

	// Hold the finished block sum until scaling takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last) begin
			valid_s1 <= 1'b1;
		end else if (sum_taken) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			sum_s1 <= sum_next;
		end
	end

	assign sum_stage = '{valid: valid_s1, sum: sum_s1};

	`ADCBA_ASSERT_IMP(a_count_range, 1'b1, count_q < LAST_COUNT + 4'd1)
	`ADCBA_ASSERT_NXT(a_block_emits, accept && last, valid_s1)
	`ADCBA_ASSERT_NXT(a_block_clears, accept && last, count_q == 4'd0 && sum_q == 16'sd0)

endmodule

[rtl/adcba_scale.sv]
`timescale 1ns / 1ps

module adcba_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adcba_pkg::sum_stage_t sum_stage,
	output logic                  sum_taken,
	output adcba_pkg::mag_stage_t mag_stage,
	input  logic                  mag_taken
);
	import adcba_pkg::*;

	logic [15:0] sum_abs;
	logic [31:0] prod;
	logic [9:0]  mag;
	logic        valid_s2;
	logic        neg_s2;
	logic [9:0]  mag_s2;

	assign sum_taken = sum_stage.valid && (!valid_s2 || mag_taken);

	// Scale |sum| by 4/91 through a reciprocal multiply, truncating
	assign sum_abs = sum_stage.sum[15] ? 16'(-sum_stage.sum) : 16'(sum_stage.sum);
	assign prod    = {17'd0, sum_abs[14:0]} * SCALE_MUL;
	assign mag     = 10'(prod >> SCALE_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (sum_taken) begin
			valid_s2 <= 1'b1;
		end else if (mag_taken) begin
			valid_s2 <= 1'b0;
		end
	end

	// A negative sum that truncates to zero reports as plus
	always_ff @(posedge clk) begin
		if (sum_taken) begin
			mag_s2 <= mag;
			neg_s2 <= sum_stage.sum[15] && (mag != 10'd0);
		end
	end

	assign mag_stage = '{valid: valid_s2, neg: neg_s2, mag: mag_s2};

endmodule

[rtl/adcba_digits.sv]
`timescale 1ns / 1ps
`include "adc_block_average_to_ascii_assert.svh"

module adcba_digits (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adcba_pkg::mag_stage_t mag_stage,
	output logic                  mag_taken,
	adcba_out_if.source           results
);
	import adcba_pkg::*;

	logic        thou;
	logic [9:0]  rem1;
	logic [15:0] hun_prod;
	logic [3:0]  hun;
	logic [9:0]  rem2;
	logic [14:0] ten_prod;
	logic [3:0]  tens;
	logic [6:0]  ones_full;
	logic        valid_s3;
	logic        neg_s3;
	logic        thou_s3;
	logic [3:0]  hun_s3;
	logic [6:0]  rem_s3;
	logic        out_valid_q;
	logic        out_load;
	logic        take_s3;

	assign out_load  = !out_valid_q || results.ready;
	assign take_s3   = valid_s3 && out_load;
	assign mag_taken = mag_stage.valid && (!valid_s3 || take_s3);

	// Split off thousands and hundreds
	assign thou     = (mag_stage.mag >= THOUSAND);
	assign rem1     = thou ? mag_stage.mag - THOUSAND : mag_stage.mag;
	assign hun_prod = {6'd0, rem1} * HUN_MUL;
	assign hun      = 4'(hun_prod >> HUN_SHIFT);
	assign rem2     = rem1 - {6'd0, hun} * 10'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (mag_taken) begin
			valid_s3 <= 1'b1;
		end else if (take_s3) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mag_taken) begin
			neg_s3  <= mag_stage.neg;
			thou_s3 <= thou;
			hun_s3  <= hun;
			rem_s3  <= rem2[6:0];
		end
	end

	// Split the remainder into tens and ones
	assign ten_prod  = {8'd0, rem_s3} * TEN_MUL;
	assign tens      = 4'(ten_prod >> TEN_SHIFT);
	assign ones_full = rem_s3 - {3'd0, tens} * 7'd10;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s3) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			results.sign_char       <= neg_s3 ? ASCII_MINUS : ASCII_PLUS;
			results.digit_thousands <= ASCII_ZERO + {5'd0, thou_s3};
			results.digit_hundreds  <= ASCII_ZERO + {2'd0, hun_s3};
			results.digit_tens      <= ASCII_ZERO + {2'd0, tens};
			results.digit_ones      <= ASCII_ZERO + {2'd0, ones_full[3:0]};
		end
	end

	assign results.valid = out_valid_q;

	`ADCBA_ASSERT_IMP(a_hun_range, valid_s3, hun_s3 < 4'd10)
	`ADCBA_ASSERT_IMP(a_rem_range, valid_s3, rem_s3 < 7'd100)
	`ADCBA_ASSERT_NXT(a_result_loads, take_s3, out_valid_q)

endmodule

[rtl/adc_block_average_to_ascii.sv]
// Accepts one sample per cycle unless the pipeline stalls.
// The tenth sample of a block closes it; its sum is registered, then passes through the
// reciprocal-multiply stage and the two digit-split stages; the last one holds the result.
// Throughput: one sample per cycle; stalls only while all stages are full and ready is low.
// Reset (arst_n low, asynchronous): sum, count and all valid flags clear; no result pending.
`timescale 1ns / 1ps

module adc_block_average_to_ascii (
	input  logic        clk,
	input  logic        arst_n,
	adcba_in_if.sink    samples,
	adcba_out_if.source results
);
	import adcba_pkg::*;

	sum_stage_t sum_stage;
	mag_stage_t mag_stage;
	logic       sum_taken;
	logic       mag_taken;

	adcba_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.sum_stage (sum_stage),
		.sum_taken (sum_taken)
	);

	adcba_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_stage (sum_stage),
		.sum_taken (sum_taken),
		.mag_stage (mag_stage),
		.mag_taken (mag_taken)
	);

	adcba_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.mag_stage (mag_stage),
		.mag_taken (mag_taken),
		.results   (results)
	);

endmodule

[tb/tb_adc_block_average_to_ascii.sv]
`timescale 1ns / 1ps

module tb_adc_block_average_to_ascii;
	import adcba_pkg::*;

	typedef struct packed {
		logic [5:0] sign_char;
		logic [5:0] digit_thousands;
		logic [5:0] digit_hundreds;
		logic [5:0] digit_tens;
		logic [5:0] digit_ones;
	} ascii_readout_t;

	// Kinds of sample blocks for the random part
	typedef enum int {
		BLK_FULL_RANGE,
		BLK_NEAR_POS_MAX,
		BLK_NEAR_NEG_MIN,
		BLK_NEAR_ZERO,
		BLK_MIXED
	} block_kind_t;

	logic clk;
	logic arst_n;

	adcba_in_if  samples_ch ();
	adcba_out_if results_ch ();

	adc_block_average_to_ascii uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	// Predictor state: running block sum and sample count
	logic signed [15:0] block_sum;
	int unsigned        block_count;
	ascii_readout_t     pending_readouts[$];

	bit idle_on;
	int error_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Scale a finished block sum by 4/91 toward zero and format as sign plus four digits
	function automatic ascii_readout_t average_to_ascii(input logic signed [15:0] total);
		int             scaled;
		int unsigned    mag;
		ascii_readout_t r;
		scaled = (int'(total) * 4) / 91;
		mag = (scaled < 0) ? -scaled : scaled;
		r.sign_char       = (scaled < 0) ? ASCII_MINUS : ASCII_PLUS;
		r.digit_thousands = ASCII_ZERO + 6'((mag / 1000) % 10);
		r.digit_hundreds  = ASCII_ZERO + 6'((mag / 100) % 10);
		r.digit_tens      = ASCII_ZERO + 6'((mag / 10) % 10);
		r.digit_ones      = ASCII_ZERO + 6'(mag % 10);
		return r;
	endfunction

	// Add one accepted sample; close the block on the tenth
	task automatic accumulate_sample(input logic [11:0] code);
		block_sum = block_sum + $signed(code);
		block_count++;
		if (block_count == BLOCK_LEN) begin
			pending_readouts.push_back(average_to_ascii(block_sum));
			block_sum = '0;
			block_count = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [5:0] got, input logic [5:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// Send one sample, with an optional idle burst first; call at a rising edge
	task automatic send_sample(input logic [11:0] code);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		samples_ch.valid    <= 1'b1;
		samples_ch.adc_code <= code;
		do @(posedge clk); while (!samples_ch.ready);
		accumulate_sample(code);
	endtask

	function automatic logic [11:0] pick_sample(input block_kind_t kind);
		case (kind)
			BLK_FULL_RANGE:   return 12'($urandom_range(0, 4095));
			BLK_NEAR_POS_MAX: return 12'h7FF - 12'($urandom_range(0, 15));
			BLK_NEAR_NEG_MIN: return 12'h800 + 12'($urandom_range(0, 15));
			BLK_NEAR_ZERO:    return 12'(int'($urandom_range(0, 8)) - 4);
			default: return pick_sample(block_kind_t'($urandom_range(0, 3)));
		endcase
	endfunction

	task automatic send_random_blocks(input int n_blocks);
		block_kind_t kind;
		for (int b = 0; b < n_blocks; b++) begin
			kind = block_kind_t'($urandom_range(0, 4));
			for (int i = 0; i < BLOCK_LEN; i++) begin
				send_sample(pick_sample(kind));
			end
		end
	endtask

	// Largest positive sum, most negative sum, and a small negative sum that scales to zero
	task automatic test_extreme_blocks();
		idle_on = 1'b0;
		repeat (BLOCK_LEN) send_sample(12'h7FF);
		repeat (BLOCK_LEN) send_sample(12'h800);
		repeat (BLOCK_LEN - 1) send_sample(12'h000);
		send_sample(12'hFFF);
	endtask

	// Random blocks with idle bursts on both channels
	task automatic test_random_blocks_with_idling();
		idle_on = 1'b1;
		send_random_blocks(120);
		// Leave a partial block in flight across the phase change
		repeat ($urandom_range(1, BLOCK_LEN - 1)) send_sample(pick_sample(BLK_FULL_RANGE));
	endtask

	// Back-to-back samples with the result side always ready
	task automatic test_streaming_blocks();
		idle_on = 1'b0;
		send_random_blocks(40);
	endtask

	// Drive result-side ready, stalling in random bursts while idling is on
	initial begin
		results_ch.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each accepted result with the oldest expected readout
	always @(posedge clk) begin
		ascii_readout_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_readouts.size() == 0) begin
				report_mismatch("result with no expected readout", 1, 0);
			end else begin
				want = pending_readouts.pop_front();
				check_field("sign_char", results_ch.sign_char, want.sign_char);
				check_field("digit_thousands", results_ch.digit_thousands,
					want.digit_thousands);
				check_field("digit_hundreds", results_ch.digit_hundreds, want.digit_hundreds);
				check_field("digit_tens", results_ch.digit_tens, want.digit_tens);
				check_field("digit_ones", results_ch.digit_ones, want.digit_ones);
			end
		end
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		samples_ch.valid    = 1'b0;
		samples_ch.adc_code = '0;
		block_sum           = '0;
		block_count         = 0;
		idle_on             = 1'b0;
		error_count         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_blocks();
		test_random_blocks_with_idling();
		test_streaming_blocks();

		// Drain outstanding readouts, then let the pipeline settle
		samples_ch.valid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
